// File: sv/console_rx_ring_with_control_bytes_defines.svh
// assertion macros for the console receive ring
// used by the top level only, no other dependencies
`ifndef CONSOLE_RX_RING_WITH_CONTROL_BYTES_DEFINES_SVH
`define CONSOLE_RX_RING_WITH_CONTROL_BYTES_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CONRX_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("conrx assertion failed");

// next-cycle implication, checked outside reset
`define CONRX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("conrx assertion failed");

`endif

// File: sv/conrx_pkg.sv
// shared types and codes for the console receive ring
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package conrx_pkg;

  localparam logic [1:0] CMD_PUSH     = 2'd0;
  localparam logic [1:0] CMD_POP      = 2'd1;
  localparam logic [1:0] CMD_TAKE_INT = 2'd2;

  localparam logic [1:0] CFG_IDX_INT_CODE  = 2'd0;
  localparam logic [1:0] CFG_IDX_EOF_CODE  = 2'd1;
  localparam logic [1:0] CFG_IDX_INTERPRET = 2'd2;

  localparam logic [7:0] INT_CODE_RESET  = 8'h03;
  localparam logic [7:0] EOF_CODE_RESET  = 8'h04;
  localparam logic       INTERPRET_RESET = 1'b1;

  localparam logic [7:0] FILL_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] int_code;
    logic [7:0] eof_code;
    logic       interpret;
  } cfg_t;

  typedef struct packed {
    logic [7:0] fill_count;
    logic       interrupt_taken;
    logic       push_accepted;
    logic       end_of_file;
    logic       byte_valid;
    logic [7:0] out_byte;
  } result_t;

endpackage
`default_nettype wire

// File: sv/conrx_cfg_regs.sv
// configuration registers: control codes and interpret enable
// depends on conrx_pkg
`timescale 1ns / 1ps
`default_nettype none
module conrx_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  output conrx_pkg::cfg_t    cfg
);
  import conrx_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.int_code  <= INT_CODE_RESET;
      cfg.eof_code  <= EOF_CODE_RESET;
      cfg.interpret <= INTERPRET_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_INT_CODE:  cfg.int_code  <= cfg_data;
        CFG_IDX_EOF_CODE:  cfg.eof_code  <= cfg_data;
        CFG_IDX_INTERPRET: cfg.interpret <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/conrx_ring.sv
// ring controller: byte memory, pointers, pending flags, result register
// depends on conrx_pkg
`timescale 1ns / 1ps
`default_nettype none
module conrx_ring #(
  parameter int DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  conrx_pkg::cfg_t    cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    cmd,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          first_of_read,
  output logic               out_valid,
  input  wire logic          out_ready,
  output conrx_pkg::result_t res
);
  import conrx_pkg::*;

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = (PW > 8) ? PW : 8;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [7:0]    ring [DEPTH];
  logic [7:0]    rd_data;
  logic          st;
  logic          st_next;
  logic [PW-1:0] wp;
  logic [PW-1:0] wp_next;
  logic [PW-1:0] rp;
  logic [PW-1:0] rp_next;
  logic          eof_pend;
  logic          eof_pend_next;
  logic          int_pend;
  logic          int_pend_next;
  logic          acc;
  logic          empty;
  logic          full;
  logic          is_int;
  logic          is_eof;
  logic          mem_we;
  logic          mem_re;
  result_t       step_res;
  result_t       read_res;
  result_t       done_res;
  logic [7:0]    fill_after;
  logic [7:0]    fill_now;

  function automatic logic [7:0] sat_fill(input logic [PW-1:0] cnt);
    logic [CW-1:0] ext;
    ext = CW'(cnt);
    return (ext > CW'(FILL_MAX)) ? FILL_MAX : ext[7:0];
  endfunction

  assign in_ready = (st == ST_IDLE) && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;
  assign empty    = (wp == rp);
  assign full     = (wp + PW'(1)) == rp;
  assign is_int   = cfg.interpret && (rx_byte == cfg.int_code);
  assign is_eof   = cfg.interpret && (rx_byte == cfg.eof_code) && !is_int;

  always_comb begin
    wp_next       = wp;
    rp_next       = rp;
    eof_pend_next = eof_pend;
    int_pend_next = int_pend;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    st_next       = st;
    step_res      = '0;
    if (st == ST_READ) begin
      st_next = ST_IDLE;
    end else if (acc) begin
      case (cmd)
        CMD_PUSH: begin
          if (is_int) begin
            int_pend_next          = 1'b1;
            step_res.push_accepted = 1'b1;
          end else if (is_eof) begin
            eof_pend_next          = 1'b1;
            step_res.push_accepted = 1'b1;
          end else if (!full) begin
            mem_we                 = 1'b1;
            wp_next                = wp + PW'(1);
            step_res.push_accepted = 1'b1;
          end
        end
        CMD_POP: begin
          if (!empty) begin
            mem_re  = 1'b1;
            rp_next = rp + PW'(1);
            st_next = ST_READ;
          end else if (first_of_read && eof_pend) begin
            eof_pend_next        = 1'b0;
            step_res.end_of_file = 1'b1;
          end
        end
        CMD_TAKE_INT: begin
          if (int_pend) begin
            int_pend_next            = 1'b0;
            step_res.interrupt_taken = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign fill_after = sat_fill(wp_next - rp_next);
  assign fill_now   = sat_fill(wp - rp);

  always_comb begin
    read_res            = '0;
    read_res.out_byte   = rd_data;
    read_res.byte_valid = 1'b1;
    read_res.fill_count = fill_now;
    done_res            = step_res;
    done_res.fill_count = fill_after;
  end

  // byte memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wp] <= rx_byte;
    end
    if (mem_re) begin
      rd_data <= ring[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      wp       <= '0;
      rp       <= '0;
      eof_pend <= 1'b0;
      int_pend <= 1'b0;
    end else begin
      st       <= st_next;
      wp       <= wp_next;
      rp       <= rp_next;
      eof_pend <= eof_pend_next;
      int_pend <= int_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_READ) begin
      out_valid <= 1'b1;
    end else if (acc && !mem_re) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_READ) begin
      res <= read_res;
    end else if (acc && !mem_re) begin
      res <= done_res;
    end
  end

endmodule
`default_nettype wire

// File: sv/console_rx_ring_with_control_bytes.sv
// console receive ring with control-byte interpretation, top level
// depends on conrx_pkg, conrx_cfg_regs, conrx_ring and the defines header
//
// channel  dir  handshake         payload
// s_       in   tvalid/tready     tuser cmd, tdata rx_byte, first_of_read
// m_       out  tvalid/tready     tdata result fields, fill_count
// cfg_     in   cfg_valid/ready   cfg_index, cfg_data
//
// push, take-interrupt and an empty pop register their result directly; a pop that
// returns a byte first passes the read state, for the registered byte memory read.
// the result register lets a new item in while the previous result is taken.
// synchronous reset clears pointers and flags; memory contents are not reset.
// a stalled result holds the input side off until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "console_rx_ring_with_control_bytes_defines.svh"
module console_rx_ring_with_control_bytes #(
  parameter int RING_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // rx_byte[7:0], first_of_read[8], zero pad
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_byte, byte_valid, end_of_file,
                                      // push_accepted, interrupt_taken, fill_count
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import conrx_pkg::*;

  cfg_t    cfg;
  result_t res;

  conrx_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  conrx_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .cmd           (s_tuser),
    .rx_byte       (s_tdata[7:0]),
    .first_of_read (s_tdata[8]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .res           (res)
  );

  assign m_tdata = {4'b0000, res};

  // a result carries at most one of its flags
  `CONRX_ASSERT_NOW(a_one_flag, clk, rst, m_tvalid, $countones(m_tdata[11:8]) <= 1)
  // an accepted item either shows its result next cycle or holds off the input
  `CONRX_ASSERT_NEXT(a_acc_result, clk, rst, s_tvalid && s_tready, m_tvalid || !s_tready)
  // input held off with no result pending means a byte read finishes next cycle
  `CONRX_ASSERT_NEXT(a_read_done, clk, rst, !s_tready && !m_tvalid, m_tvalid && m_tdata[8])

endmodule
`default_nettype wire
